// ----- hw/rtl/stfc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the smoothed temperature fan control.
// No dependencies; imported by stfc_ram users and the top level.
package stfc_pkg;

  // Ring and sample geometry.
  localparam int TAPS        = 10;
  localparam int SAMPLE_BITS = 10;
  localparam int POS_W       = $clog2(TAPS);
  localparam int SUM_W       = $clog2(TAPS * ((1 << SAMPLE_BITS) - 1) + 1);

  // Floor division of the running sum by TAPS via a reciprocal multiply that is
  // exact for every sum below 2**SUM_W.
  localparam int RECIP_SHIFT = SUM_W + $clog2(TAPS);
  localparam int RECIP_W     = SUM_W + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SHIFT) + longint'(TAPS) - 1) / longint'(TAPS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Configuration register widths and reset values.
  localparam int STARTUP_W = 8;
  localparam int GAIN_W    = 16;
  localparam int OFFSET_W  = 20;
  localparam logic [STARTUP_W-1:0] STARTUP_RESET = 8'd10;
  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd5830;
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 20'd547226;

  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STARTUP = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_OFFSET  = 2'd2
  } cfg_index_t;

  // Calibration: avg * gain + offset, then the integer part from bit 16 up.
  localparam int FRAC_BITS = 16;
  localparam int CAL_W     = SAMPLE_BITS + GAIN_W + 1;
  localparam int TEMP_W    = 7;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 7'd127;

  // Fan speeds and temperature bands.
  localparam int PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [TEMP_W-1:0] TEMP_TRIP = 7'd90;
  localparam logic [TEMP_W-1:0] TEMP_B80  = 7'd80;
  localparam logic [TEMP_W-1:0] TEMP_B70  = 7'd70;
  localparam logic [TEMP_W-1:0] TEMP_B60  = 7'd60;
  localparam logic [TEMP_W-1:0] TEMP_B50  = 7'd50;
  localparam logic [TEMP_W-1:0] TEMP_B40  = 7'd40;

  // Duty = percent * 255 / 100 using a reciprocal that is exact below 43690.
  localparam int DUTY_W     = 8;
  localparam int PWM_SHIFT  = 19;
  localparam logic [12:0] PWM_RECIP = 13'd5243;

  function automatic logic [PCT_W-1:0] band_speed(input logic [TEMP_W-1:0] t);
    logic [PCT_W-1:0] s;
    if (t >= TEMP_B80)      s = 7'd100;
    else if (t >= TEMP_B70) s = 7'd80;
    else if (t >= TEMP_B60) s = 7'd60;
    else if (t >= TEMP_B50) s = 7'd40;
    else if (t >= TEMP_B40) s = 7'd20;
    else                    s = 7'd0;
    return s;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = 15'(pct) * 15'd255;
    prod   = 28'(scaled) * 28'(PWM_RECIP);
    return prod[PWM_SHIFT +: DUTY_W];
  endfunction

endpackage

// ----- hw/rtl/stfc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module stfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/smoothed_temperature_fan_control.sv -----
// Smoothed temperature fan control: ring-averaged sensor samples, fixed-point
// calibration, banded fan speed and a latching over-temperature heater trip.
// A beat passes the ring read, sum, average, calibration and output registers;
// one beat is accepted every cycle while out_stall does not hold the pipeline.
// Synchronous reset clears the ring valid bits, position, sum and stage valids,
// loads the register defaults, sets fan speed to 100 and the heater to on.
// Depends on stfc_pkg, stfc_ram.
module smoothed_temperature_fan_control
  import stfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  logic [15:0]            uptime_seconds,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TEMP_W-1:0]      temperature,
  output logic [PCT_W-1:0]       fan_percent,
  output logic [DUTY_W-1:0]      pwm_duty,
  output logic                   heater_on,
  output logic                   over_temp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [STARTUP_W-1:0] startup_seconds;
  logic [GAIN_W-1:0]    gain_q16;
  logic [OFFSET_W-1:0]  offset_q16;

  logic adv;
  logic accept;

  logic [POS_W-1:0]       ring_position;
  logic [TAPS-1:0]        ring_valid;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Stage 1: ring read in flight.
  logic                   v1;
  logic [SAMPLE_BITS-1:0] sample1;
  logic [15:0]            up1;
  logic [POS_W-1:0]       pos1;
  logic [SAMPLE_BITS-1:0] old_sample;

  // Stage 2: running sum holds this beat's total.
  logic                   v2;
  logic [15:0]            up2;
  logic [SUM_W-1:0]       running_sum;
  logic [SUM_W-1:0]       running_sum_next;
  logic [SUM_W+RECIP_W-1:0] avg_prod;

  // Stage 3: average.
  logic                   v3;
  logic [15:0]            up3;
  logic [SAMPLE_BITS-1:0] avg3;

  // Stage 4: calibrated value.
  logic                   v4;
  logic [15:0]            up4;
  logic [CAL_W-1:0]       cal4;
  logic [CAL_W-FRAC_BITS-1:0] cal_int;
  logic [TEMP_W-1:0]      temp4;

  logic [PCT_W-1:0] fan_speed;
  logic [PCT_W-1:0] fan_speed_next;
  logic             heater_state;
  logic             heater_state_next;
  logic             trip;

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_seconds <= STARTUP_RESET;
      gain_q16        <= GAIN_RESET;
      offset_q16      <= OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STARTUP: startup_seconds <= cfg_data[STARTUP_W-1:0];
        CFG_GAIN:    gain_q16        <= cfg_data[GAIN_W-1:0];
        CFG_OFFSET:  offset_q16      <= cfg_data[OFFSET_W-1:0];
        default:     ;
      endcase
    end
  end

  // The entry at the current position is read on accept and overwritten when
  // that beat leaves the first stage; the ring is at least two deep, so no read
  // can meet that write.
  stfc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(TAPS)
  ) u_ring (
    .clk  (clk),
    .we   (adv && v1),
    .waddr(pos1),
    .wdata(sample1),
    .re   (accept),
    .raddr(ring_position),
    .rdata(ram_rdata)
  );

  // Entries never written read as zero.
  assign old_sample       = ring_valid[pos1] ? ram_rdata : '0;
  assign running_sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample1);
  assign avg_prod         = (SUM_W+RECIP_W)'(running_sum) * (SUM_W+RECIP_W)'(RECIP);

  assign cal_int = cal4[CAL_W-1:FRAC_BITS];
  assign temp4   = (cal_int > (CAL_W-FRAC_BITS)'(TEMP_MAX)) ? TEMP_MAX
                                                           : cal_int[TEMP_W-1:0];

  always_comb begin
    fan_speed_next    = fan_speed;
    heater_state_next = heater_state;
    trip              = 1'b0;
    if (up4 < 16'(startup_seconds)) begin
      fan_speed_next = PCT_FULL;
    end else if (temp4 >= TEMP_TRIP) begin
      heater_state_next = 1'b0;
      trip              = 1'b1;
    end else begin
      fan_speed_next = band_speed(temp4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
      ring_valid    <= '0;
      running_sum   <= '0;
      fan_speed     <= PCT_FULL;
      heater_state  <= 1'b1;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      v4            <= 1'b0;
      out_valid     <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
      if (in_valid) begin
        ring_position <= (ring_position == POS_W'(TAPS - 1)) ? '0 : ring_position + 1'b1;
      end
      if (v1) begin
        ring_valid[pos1] <= 1'b1;
        running_sum      <= running_sum_next;
      end
      if (v4) begin
        fan_speed    <= fan_speed_next;
        heater_state <= heater_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample1     <= adc_sample;
      up1         <= uptime_seconds;
      pos1        <= ring_position;
      up2         <= up1;
      up3         <= up2;
      avg3        <= avg_prod[RECIP_SHIFT +: SAMPLE_BITS];
      up4         <= up3;
      cal4        <= CAL_W'(avg3) * CAL_W'(gain_q16) + CAL_W'(offset_q16);
      temperature <= temp4;
      fan_percent <= fan_speed_next;
      pwm_duty    <= duty_of(fan_speed_next);
      heater_on   <= heater_state_next;
      over_temp   <= trip;
    end
  end

endmodule
